[rtl/mdiu_pkg.sv]
// mdiu_pkg: shared types, constants and the quadrature step table
// for the multimode digital input unit; no dependencies
`default_nettype none
package mdiu_pkg;

  localparam int NUM_IN        = 4;
  localparam int PAIRS         = NUM_IN / 2;
  localparam int COUNT_W_DEF   = 32;
  localparam int ELAPSED_W     = 12;
  localparam int IDX_W         = 3;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 12'd4095;
  localparam logic [ELAPSED_W-1:0] WIN_DEFAULT = 12'd1000;
  localparam logic [7:0]           DEB_DEFAULT = 8'd10;
  localparam logic [7:0]           SINCE_MAX   = 8'd255;

  localparam logic [1:0] MODE_LEVEL = 2'd0;
  localparam logic [1:0] MODE_FREQ  = 2'd1;
  localparam logic [1:0] MODE_ENC   = 2'd2;

  localparam logic [1:0] EDGE_RISE  = 2'd0;
  localparam logic [1:0] EDGE_FALL  = 2'd1;

  localparam logic [IDX_W-1:0] REG_MODES    = 3'd0;
  localparam logic [IDX_W-1:0] REG_EDGE_SEL = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW   = 3'd3;

  typedef struct packed {
    logic [2*NUM_IN-1:0] modes;
    logic [2*NUM_IN-1:0] edge_sel;
    logic [7:0]          debounce;
    logic [7:0]          window;
  } cfg_t;

  // one classified sample travelling from front to back
  typedef struct packed {
    logic [NUM_IN-1:0] pins;
    logic              tick;
    logic [NUM_IN-1:0] clr;
    logic [NUM_IN-1:0] hit;
    logic [PAIRS-1:0]  up;
    logic [PAIRS-1:0]  dn;
  } item_t;

  function automatic logic [1:0] mode_of(input logic [2*NUM_IN-1:0] m, input int i);
    mode_of = m[2*i +: 2];
  endfunction

  function automatic logic pair_active(input logic [2*NUM_IN-1:0] m, input int p);
    pair_active = (m[4*p +: 2] == MODE_ENC) && (m[4*p+2 +: 2] == MODE_ENC);
  endfunction

  // {up, dn} for index {prev_a, prev_b, cur_a, cur_b}
  function automatic logic [1:0] quad_step(input logic [3:0] idx);
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  quad_step = 2'b10;
      4'd2, 4'd4, 4'd11, 4'd13: quad_step = 2'b01;
      default:                  quad_step = 2'b00;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/mdiu_fifo.sv]
// mdiu_fifo: two-entry register queue between front and back
// depends on nothing but its width parameter
`default_nettype none
module mdiu_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              not_empty
);
  logic [W-1:0] mem_r [2];
  logic         wptr_r, rptr_r;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_data   = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 2'd1;
    if (!wr_en && rd_en) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) wptr_r <= ~wptr_r;
      if (rd_en) rptr_r <= ~rptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wptr_r] <= wr_data;
  end
endmodule
`default_nettype wire

[rtl/mdiu_front.sv]
// mdiu_front: takes samples, detects edges and quadrature steps
// depends on mdiu_pkg
`default_nettype none
module mdiu_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mdiu_pkg::cfg_t              cfg,
  input  wire logic                        resync,
  input  wire logic [2*mdiu_pkg::NUM_IN-1:0] modes_nxt,
  input  wire logic                        take,
  input  wire logic [mdiu_pkg::NUM_IN-1:0] pins,
  input  wire logic                        tick,
  input  wire logic [mdiu_pkg::NUM_IN-1:0] clr,
  output mdiu_pkg::item_t                  item
);
  import mdiu_pkg::*;

  logic [NUM_IN-1:0] prev_r;
  logic [1:0]        ab_r [PAIRS];
  logic [1:0]        cur_ab [PAIRS];

  always_comb begin
    logic was, now;
    item.pins = pins;
    item.tick = tick;
    item.clr  = clr;
    for (int i = 0; i < NUM_IN; i++) begin
      was = prev_r[i];
      now = pins[i];
      case (cfg.edge_sel[2*i +: 2])
        EDGE_RISE: item.hit[i] = !was && now;
        EDGE_FALL: item.hit[i] = was && !now;
        default:   item.hit[i] = was != now;
      endcase
      if (mode_of(cfg.modes, i) != MODE_FREQ) item.hit[i] = 1'b0;
    end
    for (int p = 0; p < PAIRS; p++) begin
      cur_ab[p] = {pins[2*p], pins[2*p+1]};
      {item.up[p], item.dn[p]} = pair_active(cfg.modes, p) ?
                                 quad_step({ab_r[p], cur_ab[p]}) : 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '1;
      for (int p = 0; p < PAIRS; p++) ab_r[p] <= 2'b11;
    end else if (resync) begin
      for (int p = 0; p < PAIRS; p++)
        if (pair_active(modes_nxt, p)) ab_r[p] <= {prev_r[2*p], prev_r[2*p+1]};
    end else if (take) begin
      prev_r <= pins;
      for (int p = 0; p < PAIRS; p++)
        if (pair_active(cfg.modes, p)) ab_r[p] <= cur_ab[p];
    end
  end
endmodule
`default_nettype wire

[rtl/mdiu_div.sv]
// mdiu_div: restoring divider, one quotient bit per cycle
// depends on nothing but its width parameters
`default_nettype none
module mdiu_div #(
  parameter int NW = 42,
  parameter int DW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [NW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   trial, diff;

  assign quot  = q_r;
  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt_r <= CW'(NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
    end else if (cnt_r != '0) begin
      if (!diff[DW]) rem_r <= diff[DW-1:0];
      else           rem_r <= trial[DW-1:0];
      q_r <= {q_r[NW-2:0], !diff[DW]};
    end
  end
endmodule
`default_nettype wire

[rtl/mdiu_back.sv]
// mdiu_back: counters, debounce, window and result register
// depends on mdiu_pkg and mdiu_div
`default_nettype none
module mdiu_back #(
  parameter int COUNT_WIDTH = mdiu_pkg::COUNT_W_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mdiu_pkg::cfg_t              cfg,
  input  wire mdiu_pkg::item_t             item,
  input  wire logic                        item_valid,
  output logic                             item_pop,
  input  wire logic                        out_pop,
  output logic                             out_valid,
  output logic [mdiu_pkg::NUM_IN-1:0]      level_state,
  output logic [mdiu_pkg::NUM_IN-1:0]      changed_mask,
  output logic signed [31:0]               value_zero,
  output logic signed [31:0]               value_one,
  output logic signed [31:0]               value_two,
  output logic signed [31:0]               value_three,
  output logic                             mode_error
);
  import mdiu_pkg::*;

  localparam int NW = COUNT_WIDTH + 10;
  localparam logic [31:0] HZ_MAX = (COUNT_WIDTH < 32) ?
                                   32'((64'd1 << COUNT_WIDTH) - 64'd1) : 32'h7FFF_FFFF;
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;

  logic [2:0]             state_r, state_nxt;
  logic [2:0]             idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] edge_r [NUM_IN], edge_nxt [NUM_IN], edge_step [NUM_IN];
  logic [COUNT_WIDTH-1:0] pos_r [PAIRS], pos_nxt [PAIRS], pos_step [PAIRS];
  logic [31:0]            hz_r [NUM_IN], hz_nxt [NUM_IN];
  logic [NUM_IN-1:0]      last_r, last_nxt, last_step;
  logic [NUM_IN-1:0]      stab_r, stab_nxt, stab_step;
  logic [7:0]             since_r [NUM_IN], since_nxt [NUM_IN], since_step [NUM_IN];
  logic [ELAPSED_W-1:0]   el_r, el_nxt, el_step, win, den_r, den_nxt;
  logic [NW-1:0]          num_r, num_nxt, quot;
  logic [NUM_IN-1:0]      lvl, chg, lvl_r, lvl_nxt, chg_r, chg_nxt;
  logic                   div_start, div_done, can_emit, emit, win_end;
  logic [NUM_IN-1:0]      e_lvl, e_chg;
  logic [COUNT_WIDTH-1:0] e_pos [PAIRS];
  logic                   ov_r, ov_nxt;
  logic [NUM_IN-1:0]      ol_r, ol_nxt, oc_r, oc_nxt;
  logic [31:0]            ovals_r [NUM_IN], ovals_nxt [NUM_IN];
  logic                   oerr_r, oerr_nxt, err;
  logic [7:0]             deb;
  logic [1:0]             idx;

  assign idx          = idx_r[1:0];
  assign out_valid    = ov_r;
  assign level_state  = ol_r;
  assign changed_mask = oc_r;
  assign value_zero   = ovals_r[0];
  assign value_one    = ovals_r[1];
  assign value_two    = ovals_r[2];
  assign value_three  = ovals_r[3];
  assign mode_error   = oerr_r;
  assign can_emit     = !ov_r || out_pop;

  mdiu_div #(.NW(NW), .DW(ELAPSED_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (quot)
  );

  // per-item step
  always_comb begin
    deb = (cfg.debounce == '0) ? DEB_DEFAULT : cfg.debounce;
    win = ({4'd0, cfg.window} << 3) + ({4'd0, cfg.window} << 1);
    if (win == '0) win = WIN_DEFAULT;
    el_step = (item.tick && el_r < ELAPSED_MAX) ? el_r + 1'b1 : el_r;
    win_end = el_step >= win;
    for (int i = 0; i < NUM_IN; i++) begin
      edge_step[i] = item.clr[i] ? '0 : edge_r[i];
      if (item.hit[i]) edge_step[i] = edge_step[i] + 1'b1;
      last_step[i]  = last_r[i];
      since_step[i] = since_r[i];
      stab_step[i]  = stab_r[i];
      chg[i] = 1'b0;
      lvl[i] = 1'b0;
      if (mode_of(cfg.modes, i) == MODE_LEVEL) begin
        if (item.pins[i] != last_r[i]) begin
          last_step[i]  = item.pins[i];
          since_step[i] = '0;
        end else if (item.tick && since_r[i] < SINCE_MAX) begin
          since_step[i] = since_r[i] + 8'd1;
        end
        if (since_step[i] >= deb && item.pins[i] != stab_r[i]) begin
          stab_step[i] = item.pins[i];
          chg[i] = 1'b1;
        end
        lvl[i] = !stab_step[i];
      end
    end
    for (int p = 0; p < PAIRS; p++) begin
      pos_step[p] = (item.clr[2*p] || item.clr[2*p+1]) ? '0 : pos_r[p];
      if (item.up[p])      pos_step[p] = pos_step[p] + 1'b1;
      else if (item.dn[p]) pos_step[p] = pos_step[p] - 1'b1;
    end
    err = 1'b0;
    for (int p = 0; p < PAIRS; p++)
      if ((mode_of(cfg.modes, 2*p) == MODE_ENC) != (mode_of(cfg.modes, 2*p+1) == MODE_ENC))
        err = 1'b1;
  end

  // control and result
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    edge_nxt  = edge_r;
    pos_nxt   = pos_r;
    hz_nxt    = hz_r;
    last_nxt  = last_r;
    stab_nxt  = stab_r;
    since_nxt = since_r;
    el_nxt    = el_r;
    den_nxt   = den_r;
    num_nxt   = num_r;
    lvl_nxt   = lvl_r;
    chg_nxt   = chg_r;
    item_pop  = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    e_lvl     = lvl_r;
    e_chg     = chg_r;
    e_pos     = pos_r;
    case (state_r)
      ST_RUN: begin
        if (item_valid && can_emit) begin
          item_pop  = 1'b1;
          edge_nxt  = edge_step;
          pos_nxt   = pos_step;
          last_nxt  = last_step;
          stab_nxt  = stab_step;
          since_nxt = since_step;
          if (win_end) begin
            el_nxt    = '0;
            den_nxt   = el_step;
            idx_nxt   = '0;
            lvl_nxt   = lvl;
            chg_nxt   = chg;
            state_nxt = ST_LOAD;
          end else begin
            el_nxt = el_step;
            emit   = 1'b1;
            e_lvl  = lvl;
            e_chg  = chg;
            e_pos  = pos_step;
          end
        end
      end
      ST_LOAD: begin
        if (idx_r == IDX_W'(NUM_IN)) begin
          if (can_emit) begin
            emit      = 1'b1;
            state_nxt = ST_RUN;
          end
        end else if (mode_of(cfg.modes, int'(idx)) == MODE_FREQ) begin
          // edges times 1000 as shifts
          num_nxt   = (NW'(edge_r[idx]) << 10) - (NW'(edge_r[idx]) << 4)
                    - (NW'(edge_r[idx]) << 3);
          state_nxt = ST_START;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          hz_nxt[idx]   = (quot > NW'(HZ_MAX)) ? HZ_MAX : quot[31:0];
          edge_nxt[idx] = '0;
          idx_nxt       = idx_r + 3'd1;
          state_nxt     = ST_LOAD;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // output register
  always_comb begin
    ov_nxt    = ov_r;
    ol_nxt    = ol_r;
    oc_nxt    = oc_r;
    ovals_nxt = ovals_r;
    oerr_nxt  = oerr_r;
    if (out_pop && ov_r) ov_nxt = 1'b0;
    if (emit) begin
      ov_nxt   = 1'b1;
      ol_nxt   = e_lvl;
      oc_nxt   = e_chg;
      oerr_nxt = err;
      for (int i = 0; i < NUM_IN; i++) begin
        if (mode_of(cfg.modes, i) == MODE_ENC && (i >> 1) < PAIRS)
          ovals_nxt[i] = 32'($signed(e_pos[i >> 1]));
        else if (mode_of(cfg.modes, i) == MODE_FREQ)
          ovals_nxt[i] = hz_nxt[i];
        else
          ovals_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      idx_r   <= '0;
      ov_r    <= 1'b0;
      last_r  <= '1;
      stab_r  <= '1;
      el_r    <= '0;
      for (int i = 0; i < NUM_IN; i++) begin
        edge_r[i]  <= '0;
        hz_r[i]    <= '0;
        since_r[i] <= '0;
      end
      for (int p = 0; p < PAIRS; p++) pos_r[p] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
      last_r  <= last_nxt;
      stab_r  <= stab_nxt;
      el_r    <= el_nxt;
      edge_r  <= edge_nxt;
      hz_r    <= hz_nxt;
      since_r <= since_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r   <= den_nxt;
    num_r   <= num_nxt;
    lvl_r   <= lvl_nxt;
    chg_r   <= chg_nxt;
    ol_r    <= ol_nxt;
    oc_r    <= oc_nxt;
    ovals_r <= ovals_nxt;
    oerr_r  <= oerr_nxt;
  end
endmodule
`default_nettype wire

[rtl/multimode_digital_input_unit_core.sv]
// multimode_digital_input_unit_core: top level of the digital input unit
// depends on mdiu_pkg, mdiu_front, mdiu_fifo, mdiu_back, mdiu_div
//
//   channel  direction  handshake          payload
//   in_      in         in_push / in_full  pin_sample, ms_tick, clear_mask
//   out_     out        out_pop / out_empty level_state, changed_mask, value_*, mode_error
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// the back end takes one item per cycle while the receiver keeps up and no window is closing
// when a frequency window closes, each frequency input runs through the serial divider:
//   states ST_LOAD, then ST_START, then ST_WAIT for each frequency input
// the two-entry queue lets the front take samples while the back end divides
// a waiting result stalls the back end; two more transfers in fill the queue, then in_full
// synchronous active-low reset; pins reset idle high, all counters to zero
`default_nettype none
module multimode_digital_input_unit_core #(
  parameter int COUNT_WIDTH = mdiu_pkg::COUNT_W_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [mdiu_pkg::NUM_IN-1:0]     in_pin_sample,
  input  wire logic                            in_ms_tick,
  input  wire logic [mdiu_pkg::NUM_IN-1:0]     in_clear_mask,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [mdiu_pkg::NUM_IN-1:0]          out_level_state,
  output logic [mdiu_pkg::NUM_IN-1:0]          out_changed_mask,
  output logic signed [31:0]                   out_value_zero,
  output logic signed [31:0]                   out_value_one,
  output logic signed [31:0]                   out_value_two,
  output logic signed [31:0]                   out_value_three,
  output logic                                 out_mode_error,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mdiu_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [7:0]                      cfg_wdata
);
  import mdiu_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  logic                resync;
  logic                take;
  item_t               f_item, q_item;
  logic                q_valid, q_pop, out_valid;

  // register writes; a mode or edge write resyncs the encoder pairs
  always_comb begin
    cfg_nxt = cfg_r;
    resync  = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODES: begin
          cfg_nxt.modes = cfg_wdata;
          resync = 1'b1;
        end
        REG_EDGE_SEL: begin
          cfg_nxt.edge_sel = cfg_wdata;
          resync = 1'b1;
        end
        REG_DEBOUNCE: cfg_nxt.debounce = cfg_wdata;
        REG_WINDOW:   cfg_nxt.window   = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  assign take      = in_push && !in_full;
  assign out_empty = !out_valid;

  mdiu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .resync    (resync),
    .modes_nxt (cfg_nxt.modes),
    .take      (take),
    .pins      (in_pin_sample),
    .tick      (in_ms_tick),
    .clr       (in_clear_mask),
    .item      (f_item)
  );

  // queue between classification and the counters
  mdiu_fifo #(.W($bits(item_t))) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (take),
    .wr_data   (f_item),
    .full      (in_full),
    .rd_en     (q_pop),
    .rd_data   (q_item),
    .not_empty (q_valid)
  );

  mdiu_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .item         (q_item),
    .item_valid   (q_valid),
    .item_pop     (q_pop),
    .out_pop      (out_pop),
    .out_valid    (out_valid),
    .level_state  (out_level_state),
    .changed_mask (out_changed_mask),
    .value_zero   (out_value_zero),
    .value_one    (out_value_one),
    .value_two    (out_value_two),
    .value_three  (out_value_three),
    .mode_error   (out_mode_error)
  );
endmodule
`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking bench for multimode_digital_input_unit_core
// depends on mdiu_pkg and the rtl below it; directed table, then randomized phases
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import mdiu_pkg::*;

  typedef struct packed {
    logic [3:0]        level;
    logic [3:0]        changed;
    logic [3:0][31:0]  vals;
    logic              err;
  } report_t;

  // directed rows: either a register write or one sample
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [3:0]       pins;
    logic             tick;
    logic [3:0]       clr;
    logic             exp_zero;  // expected report is all zeros
  } row_t;

  localparam int DIV_SETTLE = 200;   // four serial divisions plus slack
  localparam int WATCHDOG   = 5000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 75;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [3:0] in_pin_sample = 4'hF;
  logic in_ms_tick = 1'b0;
  logic [3:0] in_clear_mask = 4'h0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [3:0] out_level_state, out_changed_mask;
  logic signed [31:0] out_value_zero, out_value_one, out_value_two, out_value_three;
  logic out_mode_error;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  multimode_digital_input_unit_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // predictor state: registers and the unit's internal state
  // ---------------------------------------------------------------
  logic [7:0]  p_modes, p_edges, p_deb, p_win;
  logic [3:0]  p_prev_pins, p_raw, p_stable;
  logic [7:0]  p_since [4];
  logic [1:0]  p_prev_ab [2];
  logic [31:0] p_pos [2];
  logic [31:0] p_edges_cnt [4];
  logic [31:0] p_hz [4];
  int          p_elapsed;

  // quadrature step for {prev_a, prev_b, cur_a, cur_b}
  localparam int QUAD_DIR [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

  report_t expected_reports [$];
  int mismatches = 0;
  int n_items = 0, n_reports = 0, n_cfg = 0;
  int n_windows = 0, n_enc_steps = 0, n_changes = 0, n_err_items = 0;
  bit calm = 1'b0;        // no idling on either side
  bit rx_hold = 1'b0;     // long receiver hold-off requested
  bit stim_done = 1'b0;

  function automatic logic [1:0] mode_at(input int i);
    return p_modes[2*i +: 2];
  endfunction

  function automatic bit enc_pair(input int p);
    return mode_at(2*p) == MODE_ENC && mode_at(2*p+1) == MODE_ENC;
  endfunction

  task automatic reset_predictor();
    p_modes = '0; p_edges = '0; p_deb = '0; p_win = '0;
    p_prev_pins = 4'hF; p_raw = 4'hF; p_stable = 4'hF; p_elapsed = 0;
    for (int i = 0; i < 4; i++) begin
      p_since[i] = '0; p_edges_cnt[i] = '0; p_hz[i] = '0;
    end
    for (int p = 0; p < 2; p++) begin
      p_prev_ab[p] = 2'b11; p_pos[p] = '0;
    end
  endtask

  task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [7:0] data);
    case (idx)
      REG_MODES:    p_modes = data;
      REG_EDGE_SEL: p_edges = data;
      REG_DEBOUNCE: p_deb = data;
      REG_WINDOW:   p_win = data;
      default:      ;  // unknown index does nothing
    endcase
    // mode or edge writes re-align complete encoder pairs to the last sample
    if (idx == REG_MODES || idx == REG_EDGE_SEL)
      for (int p = 0; p < 2; p++)
        if (enc_pair(p)) p_prev_ab[p] = {p_prev_pins[2*p], p_prev_pins[2*p+1]};
  endtask

  task automatic predict_sample(input logic [3:0] pins, input logic tick,
                                input logic [3:0] clr, output report_t r);
    logic was, now, hit;
    logic [1:0] sel, cur;
    int dir, deb, win;
    logic [63:0] hz;
    r = '0;
    for (int i = 0; i < 4; i++) if (clr[i]) p_edges_cnt[i] = '0;
    for (int p = 0; p < 2; p++) if (clr[2*p +: 2] != 0) p_pos[p] = '0;
    // edge counting for frequency inputs
    for (int i = 0; i < 4; i++) begin
      was = p_prev_pins[i]; now = pins[i]; sel = p_edges[2*i +: 2];
      if (mode_at(i) == MODE_FREQ) begin
        if (sel == EDGE_RISE) hit = !was && now;
        else if (sel == EDGE_FALL) hit = was && !now;
        else hit = was != now;
        if (hit) p_edges_cnt[i] = p_edges_cnt[i] + 1;
      end
    end
    // 4x decoding on complete pairs
    for (int p = 0; p < 2; p++) begin
      if (enc_pair(p)) begin
        cur = {pins[2*p], pins[2*p+1]};
        dir = QUAD_DIR[{p_prev_ab[p], cur}];
        if (dir != 0) n_enc_steps++;
        p_pos[p] = p_pos[p] + dir;
        p_prev_ab[p] = cur;
      end
    end
    // debounce for level inputs, active low
    deb = (p_deb == 0) ? 10 : p_deb;
    for (int i = 0; i < 4; i++) begin
      if (mode_at(i) == MODE_LEVEL) begin
        if (pins[i] != p_raw[i]) begin
          p_raw[i] = pins[i];
          p_since[i] = '0;
        end else if (tick && p_since[i] != 8'd255) begin
          p_since[i]++;
        end
        if (p_since[i] >= deb && pins[i] != p_stable[i]) begin
          p_stable[i] = pins[i];
          r.changed[i] = 1'b1;
        end
        r.level[i] = !p_stable[i];
      end
    end
    // measurement window
    win = p_win * 10;
    if (win == 0) win = 1000;
    if (tick && p_elapsed < 4095) p_elapsed++;
    if (p_elapsed >= win) begin
      n_windows++;
      for (int i = 0; i < 4; i++) begin
        if (mode_at(i) == MODE_FREQ) begin
          hz = (64'(p_edges_cnt[i]) * 1000) / p_elapsed;
          p_hz[i] = (hz > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : hz[31:0];
          p_edges_cnt[i] = '0;
        end
      end
      p_elapsed = 0;
    end
    p_prev_pins = pins;
    for (int p = 0; p < 2; p++)
      if ((mode_at(2*p) == MODE_ENC) != (mode_at(2*p+1) == MODE_ENC)) r.err = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (mode_at(i) == MODE_ENC) r.vals[i] = p_pos[i >> 1];
      else if (mode_at(i) == MODE_FREQ) r.vals[i] = p_hz[i];
    end
    if (r.changed != 0) n_changes++;
    if (r.err) n_err_items++;
  endtask

  // ---------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= data;
    apply_register(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // pause until every report is back, then let a pending division finish
  task automatic drain_unit();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DIV_SETTLE) @(posedge clk);
  endtask

  task automatic send_sample(input logic [3:0] pins, input logic tick,
                             input logic [3:0] clr, input bit zero_exp);
    report_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1; in_pin_sample <= pins; in_ms_tick <= tick; in_clear_mask <= clr;
    do @(posedge clk); while (in_full);
    predict_sample(pins, tick, clr, r);
    // rows with a typed expectation use it in place of the predicted report
    expected_reports.push_back(zero_exp ? report_t'('0) : r);
    n_items++;
  endtask

  // directed table
  localparam int N_ROWS = 32;
  localparam row_t ROWS [N_ROWS] = '{
    // defaults after reset: all level, nothing settled yet
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b0, 4'h0, 1'b1},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b1, 4'hF, 1'b1},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b1, 4'h0, 1'b0},
    // short debounce, pins held low then released
    '{ROW_CFG,  REG_DEBOUNCE, 8'h01, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b1, 4'h0, 1'b0},
    // both pairs as encoders, one clockwise cycle, an illegal jump, a clear
    '{ROW_CFG,  REG_MODES, 8'hAA, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hE, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hC, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hD, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h4, 1'b0, 4'h2, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h1, 1'b0, 4'h0, 1'b0},
    // counter-clockwise, from below zero back up past it
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h2, 1'b0, 4'h0, 1'b0},
    // all frequency, every edge selection, 10 ms window
    '{ROW_CFG,  REG_MODES, 8'h55, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_CFG,  REG_EDGE_SEL, 8'hE4, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_CFG,  REG_WINDOW, 8'h01, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b1, 4'h5, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'hF, 1'b1, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h0, 1'b1, 4'h0, 1'b0},
    // half an encoder pair flags an error; unknown index is ignored
    '{ROW_CFG,  REG_MODES, 8'h28, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_CFG,  3'd7, 8'hFF, 4'h0, 1'b0, 4'h0, 1'b0},
    '{ROW_ITEM, 3'd0, 8'h00, 4'h3, 1'b1, 4'h0, 1'b0},
    // everything inactive reports zeros
    '{ROW_CFG,  REG_MODES, 8'hFF, 4'hA, 1'b1, 4'h0, 1'b0}
  };

  task automatic random_phase(input int ph);
    logic [7:0] modes, edges, deb, win;
    logic [3:0] pins, clr;
    int pick;
    case (ph)
      0: begin modes = 8'hAA; edges = 8'h00; deb = 8'h00; win = 8'h01; end
      1: begin modes = 8'h55; edges = 8'hE4; deb = 8'hFF; win = 8'h01; end
      2: begin modes = 8'h00; edges = 8'hFF; deb = 8'hFF; win = 8'h00; end
      3: begin modes = 8'h00; edges = 8'h1B; deb = 8'h01; win = 8'hFF; end
      4: begin modes = 8'h5A; edges = 8'h50; deb = 8'h02; win = 8'h02; end
      default: begin
        modes = 8'($urandom); edges = 8'($urandom);
        deb = 8'($urandom_range(0, 6)); win = 8'($urandom_range(0, 3));
      end
    endcase
    calm = (ph == 3);
    drain_unit();
    write_register(REG_MODES, modes);
    write_register(REG_EDGE_SEL, edges);
    write_register(REG_DEBOUNCE, deb);
    write_register(REG_WINDOW, win);
    if ($urandom_range(0, 2) == 0)
      write_register(3'($urandom_range(4, 7)), 8'($urandom));
    pins = p_prev_pins;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      // mostly one-bit steps, i.e. legal quadrature and clean level changes
      if (pick < 70) pins = pins ^ (4'b1 << $urandom_range(0, 3));
      else if (pick < 90) pins = 4'($urandom);
      clr = ($urandom_range(0, 99) < 8) ? 4'($urandom) : 4'h0;
      send_sample(pins, 1'($urandom_range(0, 1)), clr, 1'b0);
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < N_ROWS; r++) begin
      if (ROWS[r].kind == ROW_CFG) begin
        drain_unit();
        write_register(ROWS[r].idx, ROWS[r].data);
      end else begin
        send_sample(ROWS[r].pins, ROWS[r].tick, ROWS[r].clr, ROWS[r].exp_zero);
      end
    end
    send_sample(4'h5, 1'b1, 4'h0, 1'b1);
    for (int ph = 0; ph < RAND_PHASES; ph++) random_phase(ph);
    @(negedge clk);
    in_push <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------
  // receiver side: random pops, one long hold-off to fill the queue
  // ---------------------------------------------------------------
  initial begin
    bit held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_items >= 300) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (80) @(negedge clk);
      end
      out_pop <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on report %0d, %s: expected %0h, got %0h",
                 n_reports, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %0d", n_reports);
      end else begin
        want = expected_reports.pop_front();
        compare_field("level_state", want.level, out_level_state);
        compare_field("changed_mask", want.changed, out_changed_mask);
        compare_field("value_zero", want.vals[0], out_value_zero);
        compare_field("value_one", want.vals[1], out_value_one);
        compare_field("value_two", want.vals[2], out_value_two);
        compare_field("value_three", want.vals[3], out_value_three);
        compare_field("mode_error", want.err, out_mode_error);
      end
      n_reports++;
    end
  end

  // watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG);
      $display("tb_top failed");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DIV_SETTLE) @(posedge clk);
    $display("covered %0d samples, %0d reports, %0d register writes, %0d windows closed",
             n_items, n_reports, n_cfg, n_windows);
    $display("encoder steps %0d, debounced changes %0d, pair-error samples %0d",
             n_enc_steps, n_changes, n_err_items);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[multimode_digital_input_unit_core.f]
rtl/mdiu_pkg.sv
rtl/mdiu_fifo.sv
rtl/mdiu_front.sv
rtl/mdiu_div.sv
rtl/mdiu_back.sv
rtl/multimode_digital_input_unit_core.sv
test/tb_top.sv
